// File: sv/vfm_pkg.sv
// package: types, tables and helpers shared by the voxel face mesher modules
`default_nettype none

package vfm_pkg;

    // field widths
    localparam int TYPE_W   = 8;
    localparam int POS_W    = 5;
    localparam int MASK_W   = 27;
    localparam int COORD_W  = 6;
    localparam int FACE_W   = 3;
    localparam int AO_W     = 2;
    localparam int VTX_W    = 3;
    localparam int CORNER_W = 2;

    localparam int NUM_FACES = 6;
    localparam int RING_N    = 8;
    localparam int NUM_CORN  = 4;

    // stream widths: in = type, x, y, z, mask, padded to bytes
    localparam int S_TDATA_W = 56;
    localparam int M_TDATA_W = 32;

    // last vertex of a face
    localparam logic [VTX_W-1:0] LAST_VTX = VTX_W'(5);

    // queue between front and back
    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = 1;

    // per face: normal offset (x,y,z) and in-plane axes (0=x, 1=y, 2=z)
    localparam int FACE_NORM [NUM_FACES][3] = '{
        '{0, 1, 0}, '{0, -1, 0}, '{1, 0, 0}, '{-1, 0, 0}, '{0, 0, -1}, '{0, 0, 1}};
    localparam int FACE_UAX [NUM_FACES] = '{0, 0, 1, 1, 1, 1};
    localparam int FACE_VAX [NUM_FACES] = '{2, 2, 2, 2, 0, 0};

    // eight in-plane neighbors as (du, dv)
    localparam int RING [RING_N][2] = '{
        '{0, -1}, '{-1, -1}, '{-1, 0}, '{-1, 1}, '{0, 1}, '{1, 1}, '{1, 0}, '{1, -1}};

    // quad corner offsets per face, bit 2 = x, bit 1 = y, bit 0 = z
    localparam logic [2:0] CORNER [NUM_FACES][NUM_CORN] = '{
        '{3'b010, 3'b110, 3'b111, 3'b011},
        '{3'b000, 3'b100, 3'b101, 3'b001},
        '{3'b100, 3'b110, 3'b111, 3'b101},
        '{3'b000, 3'b010, 3'b011, 3'b001},
        '{3'b000, 3'b010, 3'b110, 3'b100},
        '{3'b001, 3'b011, 3'b111, 3'b101}};

    // corner emission order per face and flip
    localparam logic [CORNER_W-1:0] ORDER [NUM_FACES][2][6] = '{
        '{'{2'd0, 2'd3, 2'd2, 2'd0, 2'd2, 2'd1}, '{2'd1, 2'd0, 2'd3, 2'd1, 2'd3, 2'd2}},
        '{'{2'd0, 2'd2, 2'd3, 2'd0, 2'd1, 2'd2}, '{2'd1, 2'd3, 2'd0, 2'd1, 2'd2, 2'd3}},
        '{'{2'd0, 2'd1, 2'd2, 2'd0, 2'd2, 2'd3}, '{2'd3, 2'd0, 2'd1, 2'd3, 2'd1, 2'd2}},
        '{'{2'd0, 2'd2, 2'd1, 2'd0, 2'd3, 2'd2}, '{2'd3, 2'd1, 2'd0, 2'd3, 2'd2, 2'd1}},
        '{'{2'd0, 2'd1, 2'd2, 2'd0, 2'd2, 2'd3}, '{2'd3, 2'd0, 2'd1, 2'd3, 2'd1, 2'd2}},
        '{'{2'd0, 2'd2, 2'd1, 2'd0, 2'd3, 2'd2}, '{2'd3, 2'd1, 2'd0, 2'd3, 2'd2, 2'd1}}};

    // classified voxel as held in the queue
    typedef struct packed {
        logic [TYPE_W-1:0]                     vtype;
        logic [POS_W-1:0]                      px;
        logic [POS_W-1:0]                      py;
        logic [POS_W-1:0]                      pz;
        logic [NUM_FACES-1:0]                  vis;
        logic [NUM_FACES-1:0]                  flip;
        logic [NUM_FACES-1:0][NUM_CORN-1:0][AO_W-1:0] ao;
    } vfm_entry_t;

    // mask bit of the face neighbor
    function automatic int norm_bit(input int f);
        int dx;
        int dy;
        int dz;
        dx = FACE_NORM[f][0];
        dy = FACE_NORM[f][1];
        dz = FACE_NORM[f][2];
        return (dx + 1) + 3 * (dz + 1) + 9 * (dy + 1);
    endfunction

    // mask bit of ring neighbor k around the face neighbor
    function automatic int ring_bit(input int f, input int k);
        int d [3];
        d[0] = FACE_NORM[f][0];
        d[1] = FACE_NORM[f][1];
        d[2] = FACE_NORM[f][2];
        d[FACE_UAX[f]] = d[FACE_UAX[f]] + RING[k][0];
        d[FACE_VAX[f]] = d[FACE_VAX[f]] + RING[k][1];
        return (d[0] + 1) + 3 * (d[2] + 1) + 9 * (d[1] + 1);
    endfunction

endpackage

`default_nettype wire

// File: sv/vfm_front.sv
// front: wraps the position, finds visible faces, corner ao and flip per face
`default_nettype none

module vfm_front
    import vfm_pkg::*;
#(
    parameter int CHUNK_EDGE = 32
)
(
    input  wire logic [TYPE_W-1:0] vtype,
    input  wire logic [POS_W-1:0]  px,
    input  wire logic [POS_W-1:0]  py,
    input  wire logic [POS_W-1:0]  pz,
    input  wire logic [MASK_W-1:0] mask,
    output vfm_entry_t             entry,
    output logic                   keep
);

    logic [POS_W-1:0] wrap_tab [2**POS_W];
    logic [NUM_FACES-1:0][RING_N-1:0] open_nb;
    logic [NUM_FACES-1:0][NUM_CORN-1:0][AO_W-1:0] ao;
    logic [NUM_FACES-1:0] vis;
    logic [NUM_FACES-1:0] flip;

    // coordinate wrap table, filled at elaboration
    always_comb
    begin
        for (int i = 0; i < 2**POS_W; i++)
        begin
            wrap_tab[i] = POS_W'(i % CHUNK_EDGE);
        end
    end

    // open neighbors, visibility, corner ao and flip for every face
    always_comb
    begin
        for (int f = 0; f < NUM_FACES; f++)
        begin
            vis[f] = !mask[5'(norm_bit(f))];
            for (int k = 0; k < RING_N; k++)
            begin
                open_nb[f][k] = !mask[5'(ring_bit(f, k))];
            end
            ao[f][0] = AO_W'({1'b0, open_nb[f][0]} + {1'b0, open_nb[f][1]}
                             + {1'b0, open_nb[f][2]});
            ao[f][1] = AO_W'({1'b0, open_nb[f][6]} + {1'b0, open_nb[f][7]}
                             + {1'b0, open_nb[f][0]});
            ao[f][2] = AO_W'({1'b0, open_nb[f][4]} + {1'b0, open_nb[f][5]}
                             + {1'b0, open_nb[f][6]});
            ao[f][3] = AO_W'({1'b0, open_nb[f][2]} + {1'b0, open_nb[f][3]}
                             + {1'b0, open_nb[f][4]});
            flip[f] = ({1'b0, ao[f][1]} + {1'b0, ao[f][3]})
                    > ({1'b0, ao[f][0]} + {1'b0, ao[f][2]});
        end
    end

    // queue entry, dropped for empty or fully enclosed voxels
    always_comb
    begin
        entry.vtype = vtype;
        entry.px    = wrap_tab[px];
        entry.py    = wrap_tab[py];
        entry.pz    = wrap_tab[pz];
        entry.vis   = vis;
        entry.flip  = flip;
        entry.ao    = ao;
        keep        = (vtype != '0) && (vis != '0);
    end

endmodule

`default_nettype wire

// File: sv/vfm_queue.sv
// queue: short register fifo of classified voxels between front and back
`default_nettype none

module vfm_queue
    import vfm_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    input  wire vfm_entry_t push_data,
    output logic            full,
    input  wire logic       pop,
    output logic            head_valid,
    output vfm_entry_t      head_data
);

    vfm_entry_t        mem_reg [Q_DEPTH];
    logic [Q_AW-1:0]   wr_ptr_reg;
    logic [Q_AW-1:0]   wr_ptr_next;
    logic [Q_AW-1:0]   rd_ptr_reg;
    logic [Q_AW-1:0]   rd_ptr_next;
    logic [Q_AW:0]     count_reg;
    logic [Q_AW:0]     count_next;

    // status and head
    always_comb
    begin
        full       = (count_reg == (Q_AW+1)'(Q_DEPTH));
        head_valid = (count_reg != '0);
        head_data  = mem_reg[rd_ptr_reg];
    end

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (Q_AW+1)'(push) - (Q_AW+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// File: sv/vfm_back.sv
// back: walks the visible faces of one voxel and emits six vertices per face
`default_nettype none

module vfm_back
    import vfm_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 head_valid,
    input  wire vfm_entry_t           head_data,
    output logic                      pop,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [M_TDATA_W-1:0]      out_word,
    output logic                      out_last
);

    vfm_entry_t             cur_reg;
    logic                   cur_valid_reg;
    logic                   cur_valid_next;
    logic [NUM_FACES-1:0]   rem_reg;
    logic [NUM_FACES-1:0]   rem_next;
    logic [VTX_W-1:0]       vtx_reg;
    logic [VTX_W-1:0]       vtx_next;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic [M_TDATA_W-1:0]   out_word_reg;
    logic                   out_last_reg;

    logic [FACE_W-1:0]      face;
    logic [NUM_FACES-1:0]   face_bit;
    logic [CORNER_W-1:0]    corn;
    logic [2:0]             offs;
    logic                   flip;
    logic [COORD_W-1:0]     vx;
    logic [COORD_W-1:0]     vy;
    logic [COORD_W-1:0]     vz;
    logic [M_TDATA_W-1:0]   word;
    logic                   step;
    logic                   fin_face;
    logic                   fin_item;
    logic                   load;

    // lowest remaining face
    always_comb
    begin
        face     = '0;
        face_bit = '0;
        for (int f = NUM_FACES - 1; f >= 0; f--)
        begin
            if (rem_reg[f])
            begin
                face     = FACE_W'(f);
                face_bit = NUM_FACES'(1) << f;
            end
        end
    end

    // vertex of the current face and step
    always_comb
    begin
        flip = cur_reg.flip[face];
        corn = ORDER[face][flip][vtx_reg];
        offs = CORNER[face][corn];
        vx   = {1'b0, cur_reg.px} + COORD_W'(offs[2]);
        vy   = {1'b0, cur_reg.py} + COORD_W'(offs[1]);
        vz   = {1'b0, cur_reg.pz} + COORD_W'(offs[0]);
        word = {vx, vy, vz, cur_reg.vtype, face, cur_reg.ao[face][corn], flip};
    end

    // sequencing
    always_comb
    begin
        step     = cur_valid_reg && (!out_valid_reg || out_ready);
        fin_face = step && (vtx_reg == LAST_VTX);
        fin_item = fin_face && ((rem_reg & ~face_bit) == '0);
        load     = head_valid && (!cur_valid_reg || fin_item);
        pop      = load;

        cur_valid_next = cur_valid_reg;
        rem_next       = rem_reg;
        vtx_next       = vtx_reg;
        if (load)
        begin
            cur_valid_next = 1'b1;
            rem_next       = head_data.vis;
            vtx_next       = '0;
        end
        else if (fin_item)
        begin
            cur_valid_next = 1'b0;
        end
        else if (fin_face)
        begin
            rem_next = rem_reg & ~face_bit;
            vtx_next = '0;
        end
        else if (step)
        begin
            vtx_next = vtx_reg + 1'b1;
        end

        if (step)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            rem_reg       <= '0;
            vtx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            rem_reg       <= rem_next;
            vtx_reg       <= vtx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            cur_reg <= head_data;
        end
        if (step)
        begin
            out_word_reg <= word;
            out_last_reg <= fin_item;
        end
    end

    // output register
    always_comb
    begin
        out_valid = out_valid_reg;
        out_word  = out_word_reg;
        out_last  = out_last_reg;
    end

endmodule

`default_nettype wire

// File: sv/voxel_face_mesher_with_ao.sv
// top level of the voxel face mesher with ambient occlusion
//
//  channel  | dir | fields (lowest bit first)
//  ---------+-----+-----------------------------------------------------------
//  s_axis   | in  | tdata: voxel_type[7:0] pos_x[12:8] pos_y[17:13]
//           |     |        pos_z[22:18] solid_mask[49:23], zero pad to 56
//  m_axis   | out | tdata: vertex_word[31:0]; tlast: last vertex of the voxel
//
//  a voxel with n visible faces gives 6n vertices at one vertex per cycle
//  while the output is not stalled, from the back sequencer and its single
//  output register. empty or enclosed voxels are accepted but not queued and
//  give nothing. a two-entry queue lets the input keep accepting until it fills
//  while the output stalls. reset clears the queue, sequencer and output valid.
`default_nettype none

module voxel_face_mesher_with_ao
    import vfm_pkg::*;
#(
    parameter int CHUNK_EDGE = 32
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // voxel_type, pos_x, pos_y, pos_z, solid_mask, zero pad
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // vertex_word
    output logic [M_TDATA_W-1:0]      m_tdata,
    output logic                      m_tlast
);

    vfm_entry_t entry;
    vfm_entry_t head_data;
    logic       keep;
    logic       full;
    logic       push;
    logic       pop;
    logic       head_valid;

    // classify the incoming item
    vfm_front #(
        .CHUNK_EDGE (CHUNK_EDGE)
    ) u_front (
        .vtype (s_tdata[7:0]),
        .px    (s_tdata[12:8]),
        .py    (s_tdata[17:13]),
        .pz    (s_tdata[22:18]),
        .mask  (s_tdata[49:23]),
        .entry (entry),
        .keep  (keep)
    );

    // accept whenever the queue has room
    always_comb
    begin
        s_tready = !full;
        push     = s_tvalid && s_tready && keep;
    end

    vfm_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (entry),
        .full       (full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_data  (head_data)
    );

    // vertex emission
    vfm_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_data  (head_data),
        .pop        (pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_word   (m_tdata),
        .out_last   (m_tlast)
    );

endmodule

`default_nettype wire

// File: dv/testbench.sv
// testbench for the voxel face mesher: directed and random voxels checked vertex by vertex
`default_nettype none

module testbench;

    localparam int EDGE = 32;

    // per face: normal offset (x,y,z) and in-plane axes (0=x, 1=y, 2=z)
    localparam int NORMAL [6][3] = '{
        '{0, 1, 0}, '{0, -1, 0}, '{1, 0, 0}, '{-1, 0, 0}, '{0, 0, -1}, '{0, 0, 1}};
    localparam int U_AXIS [6] = '{0, 0, 1, 1, 1, 1};
    localparam int V_AXIS [6] = '{2, 2, 2, 2, 0, 0};

    // in-plane neighbors around the face neighbor as (du, dv)
    localparam int RING_OFS [8][2] = '{
        '{0, -1}, '{-1, -1}, '{-1, 0}, '{-1, 1}, '{0, 1}, '{1, 1}, '{1, 0}, '{1, -1}};

    // quad corner offsets, bit 2 = x, bit 1 = y, bit 0 = z
    localparam logic [2:0] QUAD_CORNER [6][4] = '{
        '{3'b010, 3'b110, 3'b111, 3'b011},
        '{3'b000, 3'b100, 3'b101, 3'b001},
        '{3'b100, 3'b110, 3'b111, 3'b101},
        '{3'b000, 3'b010, 3'b011, 3'b001},
        '{3'b000, 3'b010, 3'b110, 3'b100},
        '{3'b001, 3'b011, 3'b111, 3'b101}};

    // corner order of the two triangles per face and flip
    localparam int EMIT_ORDER [6][2][6] = '{
        '{'{0, 3, 2, 0, 2, 1}, '{1, 0, 3, 1, 3, 2}},
        '{'{0, 2, 3, 0, 1, 2}, '{1, 3, 0, 1, 2, 3}},
        '{'{0, 1, 2, 0, 2, 3}, '{3, 0, 1, 3, 1, 2}},
        '{'{0, 2, 1, 0, 3, 2}, '{3, 1, 0, 3, 2, 1}},
        '{'{0, 1, 2, 0, 2, 3}, '{3, 0, 1, 3, 1, 2}},
        '{'{0, 2, 1, 0, 3, 2}, '{3, 1, 0, 3, 2, 1}}};

    // mask bit of each face neighbor and of the voxel itself
    localparam int FACE_BIT [6] = '{22, 4, 14, 12, 10, 16};
    localparam int CENTER_BIT = 13;

    typedef struct packed {
        logic [31:0] word;
        logic        last;
    } vertex_t;

    // expected vertices of accepted voxels and the checks against them
    class vertex_board;
        vertex_t vertex_q[$];
        int      mismatches;
        int      voxels_in;
        int      quiet_voxels;
        int      vertices_out;

        function new();
            mismatches   = 0;
            voxels_in    = 0;
            quiet_voxels = 0;
            vertices_out = 0;
        endfunction

        function bit cell_void(logic [26:0] m, int dx, int dy, int dz);
            return !m[(dx + 1) + 3 * (dz + 1) + 9 * (dy + 1)];
        endfunction

        // vertices of all visible faces of one voxel
        function void mesh_voxel(input logic [7:0] vtype, input logic [4:0] px,
                                 input logic [4:0] py, input logic [4:0] pz,
                                 input logic [26:0] m, output vertex_t res[$]);
            int      d [3];
            int      lit [8];
            int      ao [4];
            int      f;
            int      k;
            int      c;
            int      ex;
            int      ey;
            int      ez;
            bit      flip;
            vertex_t v;
            res = {};
            if (vtype == 8'd0)
                return;
            ex = px % EDGE;
            ey = py % EDGE;
            ez = pz % EDGE;
            for (f = 0; f < 6; f++)
            begin
                if (!cell_void(m, NORMAL[f][0], NORMAL[f][1], NORMAL[f][2]))
                    continue;
                // occlusion ring around the face neighbor
                for (k = 0; k < 8; k++)
                begin
                    d[0] = NORMAL[f][0];
                    d[1] = NORMAL[f][1];
                    d[2] = NORMAL[f][2];
                    d[U_AXIS[f]] += RING_OFS[k][0];
                    d[V_AXIS[f]] += RING_OFS[k][1];
                    lit[k] = cell_void(m, d[0], d[1], d[2]) ? 1 : 0;
                end
                ao[0] = lit[0] + lit[1] + lit[2];
                ao[1] = lit[6] + lit[7] + lit[0];
                ao[2] = lit[4] + lit[5] + lit[6];
                ao[3] = lit[2] + lit[3] + lit[4];
                flip = (ao[1] + ao[3] > ao[0] + ao[2]);
                for (k = 0; k < 6; k++)
                begin
                    c = EMIT_ORDER[f][flip][k];
                    v.word = {6'(ex + QUAD_CORNER[f][c][2]), 6'(ey + QUAD_CORNER[f][c][1]),
                              6'(ez + QUAD_CORNER[f][c][0]), vtype, 3'(f), 2'(ao[c]), flip};
                    v.last = 1'b0;
                    res = {res, v};
                end
            end
            if (res.size() > 0)
                res[res.size() - 1].last = 1'b1;
        endfunction

        function void note_voxel(logic [7:0] vtype, logic [4:0] px, logic [4:0] py,
                                 logic [4:0] pz, logic [26:0] m);
            vertex_t res[$];
            mesh_voxel(vtype, px, py, pz, m, res);
            voxels_in++;
            if (res.size() == 0)
                quiet_voxels++;
            foreach (res[i])
                vertex_q = {vertex_q, res[i]};
        endfunction

        function void check_vertex(logic [31:0] word, logic last);
            vertex_t exp_v;
            vertices_out++;
            if (vertex_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("vertex %0d: none expected, got %h last %b",
                             vertices_out, word, last);
                return;
            end
            exp_v = vertex_q.pop_front();
            if (word !== exp_v.word || last !== exp_v.last)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("vertex %0d: expected %h last %b, got %h last %b",
                             vertices_out, exp_v.word, exp_v.last, word, last);
            end
        endfunction
    endclass

    logic                          clk;
    logic                          rst_n;
    logic                          s_tvalid;
    logic                          s_tready;
    // voxel_type, pos_x, pos_y, pos_z, solid_mask, zero pad
    logic [vfm_pkg::S_TDATA_W-1:0] s_tdata;
    logic                          m_tvalid;
    logic                          m_tready;
    // vertex_word
    logic [vfm_pkg::M_TDATA_W-1:0] m_tdata;
    logic                          m_tlast;

    // no idling on either side while set
    bit                            steady;

    vertex_board board = new();

    voxel_face_mesher_with_ao dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // clock
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // offer one voxel, with random idle cycles before it
    task automatic send_voxel(input logic [7:0] vtype, input logic [4:0] px,
                              input logic [4:0] py, input logic [4:0] pz,
                              input logic [26:0] m);
        while (!steady && $urandom_range(99) < 37)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= vfm_pkg::S_TDATA_W'({$urandom, $urandom});
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'd0, m, pz, py, px, vtype};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        board.note_voxel(vtype, px, py, pz, m);
    endtask

    function automatic logic [4:0] rand_coord();
        if ($urandom_range(7) == 0)
            return $urandom_range(1) ? 5'd31 : 5'd0;
        return 5'($urandom_range(31));
    endfunction

    function automatic logic [26:0] rand_mask();
        logic [26:0] m;
        int          solid_pct;
        int          b;
        case ($urandom_range(3))
            0: return 27'($urandom);
            1: solid_pct = 80;
            2: solid_pct = 20;
            default:
            begin
                // ground below, air above, mixed level in between
                m = 27'($urandom);
                m[8:0]   = '1;
                m[26:18] = '0;
                return m;
            end
        endcase
        for (b = 0; b < 27; b++)
            m[b] = ($urandom_range(99) < solid_pct);
        return m;
    endfunction

    // result side: random backpressure, check every accepted vertex
    initial
    begin
        m_tready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
                board.check_vertex(m_tdata, m_tlast);
            m_tready <= steady || ($urandom_range(99) >= 37);
        end
    end

    // reset, stimulus, drain and verdict
    initial
    begin
        vertex_t     trial[$];
        logic [26:0] m;
        logic [7:0]  vt;
        int          f;
        int          tries;
        int          i;
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        steady   = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty voxel in open air, full cube at the chunk corner, enclosed voxel
        send_voxel(8'd0, 5'd0, 5'd0, 5'd0, 27'd0);
        send_voxel(8'hFF, 5'd31, 5'd31, 5'd31, 27'd0);
        send_voxel(8'd1, 5'd0, 5'd0, 5'd0, '1);
        // each face alone with a closed ring, then in a random mask that flips the first visible quad
        for (f = 0; f < 6; f++)
        begin
            send_voxel(8'(f + 2), rand_coord(), rand_coord(), rand_coord(),
                       ~(27'd1 << FACE_BIT[f]));
            m = 27'($urandom) & ~(27'd1 << FACE_BIT[f]);
            for (tries = 0; tries < 200; tries++)
            begin
                board.mesh_voxel(8'h40, 5'd0, 5'd0, 5'd0, m, trial);
                if (trial.size() > 0 && trial[0].word[0])
                    break;
                m = 27'($urandom) & ~(27'd1 << FACE_BIT[f]);
            end
            send_voxel(8'(8'h40 + f), rand_coord(), rand_coord(), rand_coord(), m);
        end
        // center bit has no effect, top only, empty and enclosed
        send_voxel(8'h55, 5'd31, 5'd0, 5'd31, 27'd1 << CENTER_BIT);
        send_voxel(8'h80, 5'd0, 5'd31, 5'd0, ~(27'd1 << FACE_BIT[0]));
        send_voxel(8'd0, 5'd31, 5'd31, 5'd31, '1);

        // random voxels, one long run with no idling in the middle
        for (i = 0; i < 152; i++)
        begin
            steady = (i >= 60 && i < 110);
            vt = ($urandom_range(7) == 0) ? 8'd0 : 8'($urandom_range(255, 1));
            send_voxel(vt, rand_coord(), rand_coord(), rand_coord(), rand_mask());
        end
        steady = 1'b0;
        s_tvalid <= 1'b0;

        while (board.vertex_q.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        $display("testbench: %0d voxels sent, %0d of them empty or enclosed",
                 board.voxels_in, board.quiet_voxels);
        $display("testbench: %0d vertices checked, %0d mismatches",
                 board.vertices_out, board.mismatches);
        if (board.mismatches == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

    // watchdog
    initial
    begin
        #3000000;
        $display("testbench: done, errors");
        $finish;
    end

endmodule

`default_nettype wire
